[rtl/core/sorted_key_index_table_defines.svh]
// Assertion macros shared by the sorted key index table modules.
`ifndef SORTED_KEY_INDEX_TABLE_DEFINES_SVH
`define SORTED_KEY_INDEX_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKIT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/skit_pkg.sv]
// Package with the types, codes and sizes of the sorted key index table.
`default_nettype none

package skit_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 10;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_LK_RD,
        S_LK_CMP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       payload;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic ins_start;
        logic ins_read;
        logic ins_shift;
        logic ins_place;
        logic lk_start;
        logic lk_read;
        logic lk_lower;
        logic lk_upper;
        logic set_found;
        logic set_missing;
        logic set_full;
        logic clear;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic full;
        logic ins_at_zero;
        logic key_less;
        logic lk_empty;
        logic lk_hit;
        logic lk_probe_less;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[rtl/core/skit_ctrl.sv]
// Controller state machine of the sorted key index table.
`default_nettype none
`include "sorted_key_index_table_defines.svh"

module skit_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire skit_pkg::stat_t stat,
    output skit_pkg::cmd_t      cmd
);

    skit_pkg::state_t state_reg;
    skit_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skit_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != skit_pkg::S_IDLE);
        unique case (state_reg)
            skit_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = skit_pkg::S_DISPATCH;
                end
            end
            skit_pkg::S_DISPATCH:
            begin
                unique case (stat.op)
                    skit_pkg::OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = skit_pkg::S_FINISH;
                        end
                        else
                        begin
                            cmd.ins_start = 1'b1;
                            state_next    = skit_pkg::S_INS_RD;
                        end
                    end
                    skit_pkg::OP_LOOKUP:
                    begin
                        cmd.lk_start = 1'b1;
                        state_next   = skit_pkg::S_LK_RD;
                    end
                    skit_pkg::OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = skit_pkg::S_FINISH;
                    end
                    default:
                    begin
                        state_next = skit_pkg::S_FINISH;
                    end
                endcase
            end
            skit_pkg::S_INS_RD:
            begin
                if (stat.ins_at_zero)
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = skit_pkg::S_FINISH;
                end
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next   = skit_pkg::S_INS_CMP;
                end
            end
            skit_pkg::S_INS_CMP:
            begin
                // A strictly larger stored key moves up one place; an equal key stays put.
                if (stat.key_less)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = skit_pkg::S_INS_RD;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = skit_pkg::S_FINISH;
                end
            end
            skit_pkg::S_LK_RD:
            begin
                if (stat.lk_empty)
                begin
                    cmd.set_missing = 1'b1;
                    state_next      = skit_pkg::S_FINISH;
                end
                else
                begin
                    cmd.lk_read = 1'b1;
                    state_next  = skit_pkg::S_LK_CMP;
                end
            end
            skit_pkg::S_LK_CMP:
            begin
                if (stat.lk_hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = skit_pkg::S_FINISH;
                end
                else
                begin
                    cmd.lk_lower = stat.lk_probe_less;
                    cmd.lk_upper = !stat.lk_probe_less;
                    state_next   = skit_pkg::S_LK_RD;
                end
            end
            skit_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = skit_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skit_pkg::S_IDLE;
            end
        endcase
    end

    `SKIT_ASSERT_SAME(a_load_needs_room, clk, rst_n, cmd.load_out, stat.out_free,
        "result loaded while the output register is still occupied")
    `SKIT_ASSERT_SAME(a_one_write, clk, rst_n, 1'b1, $onehot0({cmd.ins_shift, cmd.ins_place}),
        "two table writes requested in one cycle")

endmodule

`default_nettype wire

[rtl/core/skit_dpath.sv]
// Datapath of the sorted key index table: entry memory, counters and result registers.
`default_nettype none
`include "sorted_key_index_table_defines.svh"

module skit_dpath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [1:0]                     operation,
    input  wire logic signed [skit_pkg::KEY_W-1:0] key,
    input  wire logic [skit_pkg::DATA_W-1:0]    payload,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output skit_pkg::status_t                   status,
    output logic [skit_pkg::POS_W-1:0]          position,
    output logic [skit_pkg::DATA_W-1:0]         found_payload,
    input  wire skit_pkg::cmd_t                 cmd,
    output skit_pkg::stat_t                     stat
);

    skit_pkg::entry_t mem [skit_pkg::CAPACITY];

    skit_pkg::op_t                     op_reg;
    logic signed [skit_pkg::KEY_W-1:0] key_reg;
    logic [skit_pkg::DATA_W-1:0]       payload_reg;
    logic [skit_pkg::CNT_W-1:0]        count_reg;
    logic [skit_pkg::ADDR_W-1:0]       slot_reg;
    logic [skit_pkg::CNT_W-1:0]        lo_reg;
    logic [skit_pkg::CNT_W-1:0]        hi_reg;   // one past the last live candidate
    skit_pkg::entry_t                  rdata_reg;
    skit_pkg::status_t                 res_status_reg;
    logic [skit_pkg::POS_W-1:0]        res_pos_reg;
    logic [skit_pkg::DATA_W-1:0]       res_payload_reg;
    logic                              out_valid_reg;
    skit_pkg::status_t                 out_status_reg;
    logic [skit_pkg::POS_W-1:0]        out_pos_reg;
    logic [skit_pkg::DATA_W-1:0]       out_payload_reg;

    logic [skit_pkg::CNT_W:0]          mid_sum;
    logic [skit_pkg::ADDR_W-1:0]       mid;
    logic                              mem_we;
    skit_pkg::entry_t                  mem_wdata;
    logic                              mem_re;
    logic [skit_pkg::ADDR_W-1:0]       mem_raddr;

    // Midpoint of the inclusive range [lo, hi-1], rounded down.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {{skit_pkg::CNT_W{1'b0}}, 1'b1};
    assign mid     = mid_sum[skit_pkg::ADDR_W:1];

    assign mem_we    = cmd.ins_shift || cmd.ins_place;
    assign mem_wdata = cmd.ins_shift ? rdata_reg : skit_pkg::entry_t'({key_reg, payload_reg});
    assign mem_re    = cmd.ins_read || cmd.lk_read;
    assign mem_raddr = cmd.ins_read ? (slot_reg - {{(skit_pkg::ADDR_W-1){1'b0}}, 1'b1}) : mid;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg          <= skit_pkg::op_t'(operation);
            key_reg         <= key;
            payload_reg     <= payload;
            res_status_reg  <= skit_pkg::ST_DONE;
            res_pos_reg     <= '0;
            res_payload_reg <= '0;
        end
        if (cmd.set_full)
        begin
            res_status_reg <= skit_pkg::ST_FULL;
        end
        if (cmd.set_missing)
        begin
            res_status_reg <= skit_pkg::ST_MISSING;
        end
        if (cmd.set_found)
        begin
            res_pos_reg     <= skit_pkg::POS_W'(mid);
            res_payload_reg <= rdata_reg.payload;
        end
        if (cmd.ins_start)
        begin
            slot_reg <= count_reg[skit_pkg::ADDR_W-1:0];
        end
        else if (cmd.ins_shift)
        begin
            slot_reg <= slot_reg - {{(skit_pkg::ADDR_W-1){1'b0}}, 1'b1};
        end
        if (cmd.lk_start)
        begin
            lo_reg <= '0;
            hi_reg <= count_reg;
        end
        else if (cmd.lk_lower)
        begin
            lo_reg <= skit_pkg::CNT_W'(mid) + {{(skit_pkg::CNT_W-1){1'b0}}, 1'b1};
        end
        else if (cmd.lk_upper)
        begin
            hi_reg <= skit_pkg::CNT_W'(mid);
        end
        if (cmd.load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_pos_reg     <= res_pos_reg;
            out_payload_reg <= res_payload_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.ins_place)
            begin
                count_reg <= count_reg + {{(skit_pkg::CNT_W-1){1'b0}}, 1'b1};
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.op            = op_reg;
        stat.full          = (count_reg == skit_pkg::CNT_W'(skit_pkg::CAPACITY));
        stat.ins_at_zero   = (slot_reg == '0);
        stat.key_less      = (key_reg < rdata_reg.key);
        stat.lk_empty      = (lo_reg >= hi_reg);
        stat.lk_hit        = (rdata_reg.key == key_reg);
        stat.lk_probe_less = (rdata_reg.key < key_reg);
        stat.out_free      = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign position      = out_pos_reg;
    assign found_payload = out_payload_reg;

    `SKIT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= skit_pkg::CNT_W'(skit_pkg::CAPACITY), "entry count beyond capacity")
    `SKIT_ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.clear, count_reg == '0,
        "table not empty after a clear")
    `SKIT_ASSERT_NEXT(a_place_counts, clk, rst_n, cmd.ins_place && !cmd.clear,
        count_reg == $past(count_reg) + {{(skit_pkg::CNT_W-1){1'b0}}, 1'b1},
        "insert did not add exactly one entry")

endmodule

`default_nettype wire

[rtl/core/sorted_key_index_table.sv]
// Top level of the sorted key index table: controller plus datapath.
//
//   channel  valid      stall      payload
//   input    in_valid   in_stall   operation, key, payload
//   output   out_valid  out_stall  status, position, found_payload
//
// One transaction at a time; in_stall is high from acceptance until the result reaches the
// output register. Each entry moved or probed costs a read state and a compare state: an
// insert walks entries up from the end of the table, a lookup halves its range per probe;
// a refused insert, a clear or a spare code goes straight to its result.
// Reset clears the entry count and the output valid; the memory itself needs no clearing.
// A stalled result waits in the output register while the next transaction is accepted.
`default_nettype none

module sorted_key_index_table (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        operation,
    input  wire logic signed [skit_pkg::KEY_W-1:0] key,
    input  wire logic [skit_pkg::DATA_W-1:0]       payload,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             status,
    output logic [skit_pkg::POS_W-1:0]             position,
    output logic [skit_pkg::DATA_W-1:0]            found_payload
);

    skit_pkg::cmd_t    cmd;
    skit_pkg::stat_t   stat;
    skit_pkg::status_t status_code;

    skit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    skit_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (operation),
        .key           (key),
        .payload       (payload),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status_code),
        .position      (position),
        .found_payload (found_payload),
        .cmd           (cmd),
        .stat          (stat)
    );

    assign status = status_code;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the sorted key index table against a mirrored sorted table.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]                        OP_SPARE       = 2'd3;
    localparam logic signed [skit_pkg::KEY_W-1:0] KEY_MIN        = 32'sh8000_0000;
    localparam logic signed [skit_pkg::KEY_W-1:0] KEY_MAX        = 32'sh7FFF_FFFF;
    localparam int                                HOLDOFF_CYCLES = 300;
    localparam int                                RANDOM_ROWS    = 64;
    localparam int                                FILL_ROWS      = 320;
    localparam int                                RANDOM_ITEMS   = 75;

    typedef struct {
        skit_pkg::status_t           st;
        logic [skit_pkg::POS_W-1:0]  pos;
        logic [skit_pkg::DATA_W-1:0] pl;
    } reply_t;

    // Keeps its own sorted copy of the table and the replies still owed by the block.
    class lookup_table_mirror;
        logic signed [skit_pkg::KEY_W-1:0] keys [skit_pkg::CAPACITY];
        logic [skit_pkg::DATA_W-1:0]       data [skit_pkg::CAPACITY];
        int                                count;
        reply_t                            due [$];
        int unsigned                       mismatches;
        int unsigned                       n_checked;
        int unsigned                       n_inserts;
        int unsigned                       n_refused;
        int unsigned                       n_lookups;
        int unsigned                       n_found;
        int unsigned                       n_clears;
        int unsigned                       n_spare;

        function void note_request(logic [1:0] op, logic signed [skit_pkg::KEY_W-1:0] k,
                                   logic [skit_pkg::DATA_W-1:0] pl);
            reply_t r;
            int     i;
            int     lo;
            int     hi;
            int     mid;
            r.st  = skit_pkg::ST_DONE;
            r.pos = '0;
            r.pl  = '0;
            case (op)
                skit_pkg::OP_INSERT:
                begin
                    n_inserts++;
                    if (count >= skit_pkg::CAPACITY)
                    begin
                        r.st = skit_pkg::ST_FULL;
                        n_refused++;
                    end
                    else
                    begin
                        // Walk the new entry down past strictly larger keys only.
                        i = count;
                        while (i > 0 && k < keys[i-1])
                        begin
                            keys[i] = keys[i-1];
                            data[i] = data[i-1];
                            i--;
                        end
                        keys[i] = k;
                        data[i] = pl;
                        count++;
                    end
                end
                skit_pkg::OP_LOOKUP:
                begin
                    n_lookups++;
                    r.st = skit_pkg::ST_MISSING;
                    lo   = 0;
                    hi   = count - 1;
                    while (lo <= hi)
                    begin
                        mid = (lo + hi) / 2;
                        if (keys[mid] == k)
                        begin
                            r.st  = skit_pkg::ST_DONE;
                            r.pos = mid[skit_pkg::POS_W-1:0];
                            r.pl  = data[mid];
                            n_found++;
                            lo    = hi + 1;
                        end
                        else if (keys[mid] < k)
                            lo = mid + 1;
                        else
                            hi = mid - 1;
                    end
                end
                skit_pkg::OP_CLEAR:
                begin
                    n_clears++;
                    count = 0;
                end
                default:
                    n_spare++;
            endcase
            due.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic [skit_pkg::POS_W-1:0] pos,
                                  logic [skit_pkg::DATA_W-1:0] pl);
            reply_t r;
            if (due.size() == 0)
            begin
                $display("%0t: unexpected result status %0d position %0d payload %h",
                         $time, st, pos, pl);
                mismatches++;
                return;
            end
            r = due.pop_front();
            n_checked++;
            if (st !== r.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, r.st, st);
                mismatches++;
            end
            if (pos !== r.pos)
            begin
                $display("%0t: position expected %0d actual %0d", $time, r.pos, pos);
                mismatches++;
            end
            if (pl !== r.pl)
            begin
                $display("%0t: found_payload expected %h actual %h", $time, r.pl, pl);
                mismatches++;
            end
        endfunction
    endclass

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              in_valid      = 1'b0;
    logic                              in_stall;
    logic [1:0]                        operation     = skit_pkg::OP_INSERT;
    logic signed [skit_pkg::KEY_W-1:0] key           = '0;
    logic [skit_pkg::DATA_W-1:0]       payload       = '0;
    logic                              out_valid;
    logic                              out_stall     = 1'b0;
    logic [1:0]                        status;
    logic [skit_pkg::POS_W-1:0]        position;
    logic [skit_pkg::DATA_W-1:0]       found_payload;

    int unsigned                       tx_gap_pct    = 0;
    int unsigned                       rx_stall_pct  = 0;
    logic                              holdoff_go    = 1'b0;
    logic                              rx_hold       = 1'b0;

    lookup_table_mirror                mirror;

    sorted_key_index_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .key           (key),
        .payload       (payload),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .position      (position),
        .found_payload (found_payload)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        mirror = new();
    end

    // Offers one transaction, idling first at random; returns at the falling edge after
    // acceptance so the next call can keep in_valid high without a gap.
    task automatic send_request(input logic [1:0] op,
                                input logic signed [skit_pkg::KEY_W-1:0] k,
                                input logic [skit_pkg::DATA_W-1:0] pl);
        while ($urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        operation = op;
        key       = k;
        payload   = pl;
        do
            @(posedge clk);
        while (in_stall);
        mirror.note_request(op, k, pl);
        @(negedge clk);
    endtask

    // Mostly inserts and lookups on a small table, with keys often drawn from what is stored.
    task automatic send_random_request();
        int                                r;
        int                                pick;
        logic [1:0]                        op;
        logic signed [skit_pkg::KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 3)
            op = OP_SPARE;
        else if (r < 8)
            op = skit_pkg::OP_CLEAR;
        else if (r < 52)
            op = (mirror.count >= RANDOM_ROWS) ? skit_pkg::OP_CLEAR : skit_pkg::OP_INSERT;
        else
            op = skit_pkg::OP_LOOKUP;
        pick = $urandom_range(0, 99);
        if (mirror.count > 0 && pick < ((op == skit_pkg::OP_LOOKUP) ? 65 : 25))
            k = mirror.keys[$urandom_range(0, mirror.count - 1)];
        else if (pick < 80)
            k = $urandom_range(0, 255) - 128;
        else
            k = $urandom;
        send_request(op, k, $urandom);
    endtask

    // Receiver side: random stalls, or a solid hold-off while the pressure window is open.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold)
                out_stall = 1'b1;
            else
                out_stall = ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    initial
    begin
        wait (holdoff_go);
        rx_hold = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            mirror.check_reply(status, position, found_payload);
    end

    initial
    begin
        #50_000_000;
        $display("Timed out with %0d results outstanding.", mirror.due.size());
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        int                                i;
        logic signed [skit_pkg::KEY_W-1:0] k;
        logic signed [skit_pkg::KEY_W-1:0] prev;
        prev = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        tx_gap_pct   = 23;
        rx_stall_pct = 58;

        // Empty table, spare code, extremes of key and payload, duplicates.
        send_request(skit_pkg::OP_LOOKUP, 0, 32'hFFFF_FFFF);
        send_request(OP_SPARE, KEY_MAX, 32'hFFFF_FFFF);
        send_request(skit_pkg::OP_INSERT, KEY_MAX, 32'hFFFF_FFFF);
        send_request(skit_pkg::OP_INSERT, KEY_MIN, 32'h0000_0000);
        send_request(skit_pkg::OP_INSERT, 0, 32'hA5A5_A5A5);
        send_request(skit_pkg::OP_INSERT, -1, 32'h5A5A_5A5A);
        send_request(skit_pkg::OP_INSERT, 0, 32'h0000_0001);
        send_request(skit_pkg::OP_INSERT, 0, 32'h0000_0002);
        send_request(skit_pkg::OP_LOOKUP, KEY_MAX, 0);
        send_request(skit_pkg::OP_LOOKUP, KEY_MIN, 32'hFFFF_FFFF);
        send_request(skit_pkg::OP_LOOKUP, 0, 0);
        send_request(skit_pkg::OP_LOOKUP, -1, 0);
        send_request(skit_pkg::OP_LOOKUP, 1, 0);
        send_request(skit_pkg::OP_LOOKUP, KEY_MAX - 1, 0);
        send_request(OP_SPARE, $urandom, $urandom);
        send_request(skit_pkg::OP_CLEAR, KEY_MIN, 32'hFFFF_FFFF);
        send_request(skit_pkg::OP_LOOKUP, 0, 0);
        send_request(skit_pkg::OP_INSERT, 5, 32'h1234_5678);
        send_request(skit_pkg::OP_LOOKUP, 5, 0);

        // Fill part of the table in ascending order, then insert the smallest key so that
        // every stored entry has to move.
        send_request(skit_pkg::OP_CLEAR, 0, 0);
        for (i = 0; i < FILL_ROWS; i++)
        begin
            if (i % 64 == 63)
                k = prev;
            else
                k = KEY_MIN + (i << 22) + $urandom_range(1, (1 << 22) - 1);
            prev = k;
            send_request(skit_pkg::OP_INSERT, k, $urandom);
        end
        send_request(skit_pkg::OP_INSERT, KEY_MIN, $urandom);
        send_request(skit_pkg::OP_INSERT, KEY_MAX, $urandom);
        send_request(skit_pkg::OP_INSERT, KEY_MIN, $urandom);
        send_request(skit_pkg::OP_LOOKUP, KEY_MIN, 0);
        send_request(skit_pkg::OP_LOOKUP, mirror.keys[mirror.count - 1], 0);
        send_request(skit_pkg::OP_LOOKUP, mirror.keys[mirror.count / 2], 0);
        send_request(skit_pkg::OP_LOOKUP, KEY_MAX, 0);
        for (i = 0; i < 8; i++)
            send_request(skit_pkg::OP_LOOKUP,
                         mirror.keys[$urandom_range(0, mirror.count - 1)], 0);
        send_request(skit_pkg::OP_CLEAR, 0, 0);

        for (i = 0; i < RANDOM_ITEMS; i++)
            send_random_request();

        tx_gap_pct   = 58;
        rx_stall_pct = 23;
        for (i = 0; i < RANDOM_ITEMS; i++)
            send_random_request();

        // No idling from here on; the receiver holds off at the start so the block fills up.
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        holdoff_go   = 1'b1;
        for (i = 0; i < RANDOM_ITEMS; i++)
            send_random_request();
        in_valid = 1'b0;

        while (mirror.due.size() != 0)
            @(posedge clk);
        repeat (2 * skit_pkg::CAPACITY + 8) @(posedge clk);

        $display("Checked %0d results: %0d inserts (%0d refused as full), %0d lookups (%0d hits),",
                 mirror.n_checked, mirror.n_inserts, mirror.n_refused, mirror.n_lookups,
                 mirror.n_found);
        $display("%0d clears, %0d spare codes; a shift past %0d entries, a %0d-cycle hold-off.",
                 mirror.n_clears, mirror.n_spare, FILL_ROWS, HOLDOFF_CYCLES);
        if (mirror.mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
